// File: rtl/g2l_pkg.sv
package g2l_pkg;

  localparam int unsigned TERM_FIRST_YEAR = 1970;
  localparam int unsigned TERM_YEARS = 69;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PREV,
    ST_WALK,
    ST_NEXT,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    KIND_LEAP     = 3'd0,
    KIND_HOLIDAY  = 3'd1,
    KIND_FESTIVAL = 3'd2,
    KIND_TERM     = 3'd3,
    KIND_MONTH    = 3'd4,
    KIND_DAY      = 3'd5
  } label_kind_t;

  typedef struct packed {
    logic [8:0]  new_year_doy;
    logic [19:0] month_bits;
  } year_entry_t;

  typedef struct packed {
    logic        date_valid;
    logic [10:0] lunar_year;
    logic [3:0]  lunar_month;
    logic        leap_month;
    logic [4:0]  lunar_day;
    logic [3:0]  holiday_code;
    logic [3:0]  festival_code;
    logic [4:0]  term_code;
    logic [2:0]  label_kind;
  } result_t;

  function automatic logic [15:0] new_year_date(input logic [6:0] i);
    logic [15:0] t [0:72];
    t = '{16'd130,16'd217,16'd206,
      16'd127,16'd215,16'd203,16'd123,16'd211,16'd131,16'd218,16'd207,16'd128,16'd216,
      16'd205,16'd125,16'd213,16'd202,16'd220,16'd209,16'd219,16'd217,16'd206,16'd127,
      16'd215,16'd204,16'd123,16'd210,16'd131,16'd219,16'd207,16'd128,16'd216,16'd205,
      16'd124,16'd212,16'd201,16'd122,16'd209,16'd129,16'd218,16'd207,16'd126,16'd214,
      16'd203,16'd123,16'd210,16'd131,16'd219,16'd208,16'd128,16'd216,16'd205,16'd125,
      16'd212,16'd201,16'd122,16'd210,16'd129,16'd217,16'd206,16'd126,16'd213,16'd203,
      16'd123,16'd211,16'd131,16'd219,16'd208,16'd128,16'd215,16'd204,16'd124,16'd212};
    return (i < 7'd73) ? t[i] : 16'd0;
  endfunction

  function automatic logic [8:0] new_year_doy(input logic [6:0] i);
    logic [8:0] t [0:72];
    t = '{9'd30,9'd48,9'd37,
      9'd27,9'd46,9'd34,9'd23,9'd42,9'd31,9'd49,9'd38,9'd28,9'd47,
      9'd36,9'd25,9'd44,9'd33,9'd51,9'd40,9'd50,9'd48,9'd37,9'd27,
      9'd46,9'd35,9'd23,9'd41,9'd31,9'd50,9'd38,9'd28,9'd47,9'd36,
      9'd24,9'd43,9'd32,9'd22,9'd40,9'd29,9'd49,9'd38,9'd26,9'd45,
      9'd34,9'd23,9'd41,9'd31,9'd50,9'd39,9'd28,9'd47,9'd36,9'd25,
      9'd43,9'd32,9'd22,9'd41,9'd29,9'd48,9'd37,9'd26,9'd44,9'd34,
      9'd23,9'd42,9'd31,9'd50,9'd39,9'd28,9'd46,9'd35,9'd24,9'd43};
    return (i < 7'd73) ? t[i] : 9'd0;
  endfunction

  function automatic logic [19:0] month_bits(input logic [6:0] i);
    logic [19:0] t [0:72];
    t = '{20'd461653,20'd1386,20'd2413,
      20'd330077,20'd1197,20'd2637,20'd268877,20'd3365,20'd531109,20'd2900,20'd2922,
      20'd398042,20'd2395,
      20'd1179,20'd267415,20'd2635,20'd661067,20'd1701,20'd1748,20'd398772,20'd2742,
      20'd2391,20'd330031,
      20'd1175,20'd1611,20'd200010,20'd3749,20'd527717,20'd1452,20'd2742,20'd332397,
      20'd2350,20'd3222,
      20'd268949,20'd3402,20'd3493,20'd133973,20'd1386,20'd464219,20'd605,20'd2349,
      20'd334123,20'd2709,
      20'd2890,20'd267946,20'd2773,20'd592565,20'd1210,20'd2651,20'd395863,20'd1323,
      20'd2707,20'd265877,
      20'd1706,20'd2773,20'd133557,20'd1206,20'd398510,20'd2638,20'd3366,20'd335142,
      20'd3411,20'd1450,
      20'd200042,20'd2413,20'd723293,20'd1197,20'd2637,20'd399947,20'd3365,20'd3410,
      20'd334676,20'd2906};
    return (i < 7'd73) ? t[i] : 20'd0;
  endfunction

  function automatic logic [7:0] term_byte(input logic [6:0] yi, input logic [3:0] mi);
    logic [95:0] r;
    logic [95:0] t [0:68];
    t = '{
      96'h95B496A5969788787869_7887, 96'h96B496A697977879796978_77,
      96'h96A4A5A5A6A6888888788787, 96'hA5B596A5A696887878788787,
      96'h95B496A59697887878697887, 96'h96B496A69797787978697877,
      96'h96A4A5B5A6A6888988788787, 96'hA5B496A59696888878788787,
      96'h95B496A59697887878797887, 96'h96B496A69697787978697877,
      96'h96A4A5B5A6A6888888788787, 96'hA5B496A5A696888878787787,
      96'h95B496A59697887878797787, 96'h95B496A59697787978697877,
      96'h96B4A5B5A6A6878888788787, 96'hA5B4A6A5A696888878788787,
      96'hA5B496A59697887878797787, 96'h95B496A59697887978697887,
      96'h96B4A5B5A6A6878888788786, 96'hA5B4A5A5A696888888788787,
      96'hA5B496A59696887878797787, 96'h95B496A58697887878697887,
      96'h96B4A5B5A6A6878888788786, 96'hA5B3A5A5A696888888788787,
      96'hA5B496A59696887878788787, 96'h95B496A59697887678697887,
      96'h96B4A5B5A6A6878888788786, 96'hA5B3A5A5A6A6888888788787,
      96'hA5B496A59696887878788787, 96'h95B496A59697887878697887,
      96'h96B4A5B5A6A6878888788786, 96'hA5B3A5A5A6A6888888788787,
      96'hA5B496A59696887878788787, 96'h95B496A59697887878697887,
      96'h96B4A5B5A6A6878888788786, 96'hA5B3A5A5A6A6888888788787,
      96'hA5B496A5A696888878788787, 96'h95B496A59697887878697887,
      96'h96B4A5B5A6A6878887788786, 96'hA5B3A5B5A6A6888888788787,
      96'hA5B496A5A696888878788787, 96'h95B496A59697887878797887,
      96'h96B4A5B5A5A6878887788786, 96'hA5B3A5B5A6A6878888788787,
      96'hA5B496A5A696888878788787, 96'h95B496A59697887878797787,
      96'h95B4A5B4A5A6878887788786, 96'hA5C3A5B5A6A6878888788787,
      96'hA5B4A6A5A696888878788787, 96'hA5B496A59696887878797787,
      96'h95B4A5B4A5A6978787788786, 96'hA5C3A5B5A6A6878888788786,
      96'hA5B4A5A5A696888888788787, 96'hA5B496A59696887878797787,
      96'h95B4A5B4A5A6978787788796, 96'hA5C3A5B5A6A6878888788786,
      96'hA5B3A5A5A6A6888888788787, 96'hA5B496A59696887878788787,
      96'h95B4A5B4A5A6978787788796, 96'hA5C3A5B5A6A6878888788786,
      96'hA5B3A5A5A6A6888888788787, 96'hA5B496A59696887878788787,
      96'h95B4A5B4A5A6978787788796, 96'hA5C3A5B5A6A6888888788786,
      96'hA5B3A5A5A6A6887888788787, 96'hA5B496A5A696888878788787,
      96'h95B4A5B4A5A6978787788796, 96'hA5C3A5B5A6A6878888788786,
      96'hA5B3A5A5A6A6888888788787};
    r = (yi < 7'd69) ? t[yi] : 96'd0;
    return r[8*(11-mi) +: 8];
  endfunction

  // exact for 1901 through 2099, which covers every supported year
  function automatic logic is_leap(input logic [11:0] y);
    return (y[1:0] == 2'd0) && (y != 12'd1900) && (y != 12'd2100);
  endfunction

endpackage

// File: rtl/g2l_if.sv
interface g2l_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] greg_year;
  logic [3:0]  greg_month;
  logic [4:0]  greg_day;
  modport source (output valid, greg_year, greg_month, greg_day, input ready);
  modport sink (input valid, greg_year, greg_month, greg_day, output ready);
endinterface

interface g2l_out_if;
  logic        valid;
  logic        ready;
  logic        date_valid;
  logic [10:0] lunar_year;
  logic [3:0]  lunar_month;
  logic        leap_month;
  logic [4:0]  lunar_day;
  logic [3:0]  holiday_code;
  logic [3:0]  festival_code;
  logic [4:0]  term_code;
  logic [2:0]  label_kind;
  modport source (output valid, date_valid, lunar_year, lunar_month, leap_month, lunar_day,
                  holiday_code, festival_code, term_code, label_kind, input ready);
  modport sink (input valid, date_valid, lunar_year, lunar_month, leap_month, lunar_day,
                holiday_code, festival_code, term_code, label_kind, output ready);
endinterface

// File: rtl/g2l_year_rom.sv
module g2l_year_rom
  import g2l_pkg::*;
(
  input  logic        clk,
  input  logic [6:0]  addr,
  output year_entry_t data
);
  always_ff @(posedge clk) begin
    data.new_year_doy <= new_year_doy(addr);
    data.month_bits   <= month_bits(addr);
  end
endmodule

// File: rtl/g2l_term_rom.sv
module g2l_term_rom
  import g2l_pkg::*;
(
  input  logic       clk,
  input  logic [6:0] year_idx,
  input  logic [3:0] month_idx,
  output logic [7:0] data
);
  always_ff @(posedge clk) begin
    data <= term_byte(year_idx, month_idx);
  end
endmodule

// File: rtl/gregorian_to_lunar_date_top.sv
// Sequence: an out-of-range date goes straight from request to result; a valid one
// passes through read, an optional previous-year read, one walk step per lunar month
// walked (at most 13 months per year over two years), and finish.
// The walk takes a later year's word from the package table; the year ROM is registered.
// Requests: a new request is taken only in idle, once the previous result has been taken.
// Reset: synchronous rst returns the controller to idle with no result pending.
module gregorian_to_lunar_date_top
  import g2l_pkg::*;
#(
  parameter int BASE_YEAR  = 1968,
  parameter int YEAR_COUNT = 73
) (
  input logic   clk,
  input logic   rst,
  g2l_in_if.sink    req,
  g2l_out_if.source rsp
);
  state_t      state, state_next;
  logic [11:0] y;
  logic [3:0]  m;
  logic [4:0]  d;
  logic [6:0]  idx;
  logic [8:0]  doy;
  logic [9:0]  rem;
  logic [3:0]  n;
  logic [3:0]  k;
  logic [3:0]  ord;
  logic [4:0]  len;
  logic        pass;
  logic        done;
  logic [19:0] data;
  logic [6:0]  rom_addr;
  year_entry_t rom_q;
  logic [7:0]  term_q;
  result_t     res;
  logic        in_range;
  logic [8:0]  doy_calc;
  logic [8:0]  db;
  logic [4:0]  cur_len;
  logic [3:0]  leap;
  logic [3:0]  mon;
  logic        lflag;
  logic [3:0]  hol, fest;
  logic [4:0]  term;
  logic [15:0] hkey, fkey;
  logic [4:0]  lday;

  always_comb begin
    in_range = (32'(req.greg_year) > BASE_YEAR) && (32'(req.greg_year) < BASE_YEAR + YEAR_COUNT)
      && (32'(req.greg_year) - BASE_YEAR < 73)
      && req.greg_month >= 4'd1 && req.greg_month <= 4'd12 && req.greg_day != 5'd0;
    case (req.greg_month)
      4'd2: db = 9'd31;  4'd3: db = 9'd59;  4'd4: db = 9'd90;  4'd5: db = 9'd120;
      4'd6: db = 9'd151; 4'd7: db = 9'd181; 4'd8: db = 9'd212; 4'd9: db = 9'd243;
      4'd10: db = 9'd273; 4'd11: db = 9'd304; 4'd12: db = 9'd334;
      default: db = 9'd0;
    endcase
    doy_calc = db + 9'(req.greg_day)
      + 9'((req.greg_month > 4'd2 && is_leap(req.greg_year)) ? 1 : 0);
  end

  always_comb begin
    rom_addr = idx;
    if (state == ST_IDLE) rom_addr = 7'(32'(req.greg_year) - BASE_YEAR);
    else if (state == ST_READ) rom_addr = idx - 7'd1;
  end

  g2l_year_rom u_year (.clk(clk), .addr(rom_addr), .data(rom_q));
  g2l_term_rom u_term (.clk(clk), .year_idx(7'(32'(y) - TERM_FIRST_YEAR)),
                       .month_idx(m - 4'd1), .data(term_q));

  assign cur_len = 5'd29 + 5'(data[n]);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (req.valid) state_next = in_range ? ST_READ : ST_OUT;
      ST_READ:   state_next = (doy < rom_q.new_year_doy) ? ST_PREV : ST_WALK;
      ST_PREV:   state_next = ST_WALK;
      ST_WALK: begin
        if (10'(cur_len) >= rem) state_next = ST_FINISH;
        else if (n == 4'd0) begin
          if (pass || 32'(idx) + 1 >= YEAR_COUNT || 32'(idx) + 1 >= 73)
            state_next = ST_FINISH;
          else state_next = ST_NEXT;
        end
      end
      ST_NEXT:   state_next = ST_WALK;
      ST_FINISH: state_next = ST_OUT;
      ST_OUT:    if (rsp.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        y <= req.greg_year; m <= req.greg_month; d <= req.greg_day;
        idx <= rom_addr; doy <= doy_calc; pass <= 1'b0; done <= 1'b0;
        res <= '0;
      end
      ST_READ: begin
        if (doy < rom_q.new_year_doy) begin
          idx <= idx - 7'd1;
        end else begin
          rem <= 10'(doy - rom_q.new_year_doy) + 10'd1;
          data <= rom_q.month_bits;
          k <= (rom_q.month_bits[19:16] != 4'd0) ? 4'd12 : 4'd11;
          n <= (rom_q.month_bits[19:16] != 4'd0) ? 4'd12 : 4'd11;
        end
      end
      ST_PREV: begin
        rem <= 10'd365 + 10'(is_leap(y - 12'd1)) + 10'(doy) - 10'(rom_q.new_year_doy) + 10'd1;
        data <= rom_q.month_bits;
        k <= (rom_q.month_bits[19:16] != 4'd0) ? 4'd12 : 4'd11;
        n <= (rom_q.month_bits[19:16] != 4'd0) ? 4'd12 : 4'd11;
      end
      ST_WALK: begin
        len <= cur_len;
        ord <= k - n + 4'd1;
        if (10'(cur_len) >= rem) done <= 1'b1;
        else begin
          rem <= rem - 10'(cur_len);
          if (n == 4'd0) begin
            if (!(32'(idx) + 1 >= YEAR_COUNT || 32'(idx) + 1 >= 73))
              idx <= idx + 7'd1;
          end else n <= n - 4'd1;
        end
      end
      ST_NEXT: begin
        pass <= 1'b1;
        data <= month_bits(idx);
        k <= (month_bits(idx)[19:16] != 4'd0) ? 4'd12 : 4'd11;
        n <= (month_bits(idx)[19:16] != 4'd0) ? 4'd12 : 4'd11;
      end
      ST_FINISH: begin
        res.date_valid <= 1'b1;
        res.lunar_year <= 11'(BASE_YEAR + 32'(idx));
        res.lunar_month <= mon;
        res.leap_month <= lflag;
        res.lunar_day <= lday;
        res.holiday_code <= hol;
        res.festival_code <= fest;
        res.term_code <= term;
        if (lday == 5'd1 && lflag) res.label_kind <= KIND_LEAP;
        else if (hol != 4'd0) res.label_kind <= KIND_HOLIDAY;
        else if (fest != 4'd0) res.label_kind <= KIND_FESTIVAL;
        else if (term != 5'd0) res.label_kind <= KIND_TERM;
        else if (lday == 5'd1) res.label_kind <= KIND_MONTH;
        else res.label_kind <= KIND_DAY;
      end
      default: ;
    endcase
  end

  always_comb begin
    leap = data[19:16];
    lday = done ? rem[4:0] : len;
    mon = ord;
    lflag = 1'b0;
    if (leap != 4'd0) begin
      if (ord == leap + 4'd1) begin
        mon = leap; lflag = 1'b1;
      end else if (ord > leap + 4'd1) mon = ord - 4'd1;
    end
    hkey = {4'd0, m, 3'd0, d};
    case (hkey)
      16'h0101: hol = 4'd1;  16'h020E: hol = 4'd2;  16'h0308: hol = 4'd3;
      16'h0401: hol = 4'd4;  16'h0501: hol = 4'd5;  16'h0504: hol = 4'd6;
      16'h0601: hol = 4'd7;  16'h0701: hol = 4'd8;  16'h0801: hol = 4'd9;
      16'h090A: hol = 4'd10; 16'h0A01: hol = 4'd11; 16'h0C18: hol = 4'd12;
      default: hol = 4'd0;
    endcase
    fkey = {4'd0, mon, 3'd0, lday};
    case (fkey)
      16'h0101: fest = 4'd1; 16'h010F: fest = 4'd2; 16'h0202: fest = 4'd3;
      16'h0505: fest = 4'd4; 16'h0707: fest = 4'd5; 16'h080F: fest = 4'd6;
      16'h0909: fest = 4'd7; 16'h0C08: fest = 4'd8;
      default: fest = 4'd0;
    endcase
    if (lflag) fest = 4'd0;
    term = 5'd0;
    if (32'(y) >= TERM_FIRST_YEAR && 32'(y) < TERM_FIRST_YEAR + TERM_YEARS) begin
      if (d < 5'd15 && {1'b0, term_q[7:4]} == 5'd15 - d) term = {m, 1'b0} - 5'd1;
      else if (d > 5'd15 && {1'b0, term_q[3:0]} == d - 5'd15) term = {m, 1'b0};
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = (state == ST_OUT);
  assign rsp.date_valid = res.date_valid;
  assign rsp.lunar_year = res.lunar_year;
  assign rsp.lunar_month = res.lunar_month;
  assign rsp.leap_month = res.leap_month;
  assign rsp.lunar_day = res.lunar_day;
  assign rsp.holiday_code = res.holiday_code;
  assign rsp.festival_code = res.festival_code;
  assign rsp.term_code = res.term_code;
  assign rsp.label_kind = res.label_kind;
endmodule
